// File: design/b2da_pkg.sv
// shared types, constants and a helper function for the binary to decimal ascii converter
package b2da_pkg;

	localparam int DEF_VALUE_BITS = 32;
	localparam int BITS_PER_STEP  = 4;
	localparam int TOTAL_BITS     = 4;
	localparam int CHAR_BITS      = 6;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_NINE = 6'd57;

	// floor(bits * log10(2)) + 1 is the digit count of 2**bits, an upper bound
	function automatic int digits_for(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: design/binary_to_decimal_ascii.sv
// top level: converts an unsigned binary value to ascii decimal digits
// an item is taken when start is high and busy low; busy then holds while the item is converted and pushed
// a new item is not taken until the current one has been pushed to the queue
// digits strobe out most significant first, one digit a cycle within an item
// a two-entry queue decouples the halves; above 39 bits long values can fill it and stretch busy
// async active-low reset clears control state only; no memory clearing pass is needed
module binary_to_decimal_ascii import b2da_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  strobe,
	output logic [CHAR_BITS-1:0]  digit_char,
	output logic [TOTAL_BITS-1:0] digit_total,
	output logic                  is_last
);

	localparam int DIGITS = digits_for(VALUE_BITS);
	localparam int EW     = DIGITS * 4 + $clog2(DIGITS + 1);

	q_status_t     q_status;
	logic          push;
	logic          pop;
	logic [EW-1:0] push_data;
	logic [EW-1:0] head;

	b2da_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	b2da_queue #(.W(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	b2da_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.digit_char  (digit_char),
		.digit_total (digit_total),
		.is_last     (is_last)
	);

endmodule

// File: design/b2da_front.sv
// front end: takes an item and converts it to packed bcd, four bits per cycle
module b2da_front import b2da_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	input  q_status_t             q_status,
	output logic                  push,
	output logic [digits_for(VALUE_BITS)*4+$clog2(digits_for(VALUE_BITS)+1)-1:0] push_data
);

	localparam int DIGITS = digits_for(VALUE_BITS);
	localparam int CW     = $clog2(DIGITS + 1);
	localparam int BCD_W  = DIGITS * 4;
	localparam int STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD    = STEPS * BITS_PER_STEP;
	localparam int SW     = $clog2(STEPS + 1);

	front_state_t        state_q, state_d;
	logic [PAD-1:0]      sh_q;
	logic [BCD_W-1:0]    bcd_q, bcd_d;
	logic [SW-1:0]       step_q;
	logic [CW-1:0]       count;
	logic                accept;

	assign accept = start && (state_q == F_IDLE);

	// shift-add-3 over the next four value bits
	always_comb begin
		logic [BCD_W-1:0] b;
		b = bcd_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (b[d*4 +: 4] >= 4'd5)
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], sh_q[PAD-1-s]};
		end
		bcd_d = b;
	end

	// highest nonzero digit sets the count, zero still has one digit
	always_comb begin
		count = CW'(1);
		for (int d = 1; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0)
				count = CW'(d + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				step_q <= '0;
			else if (state_q == F_CONV)
				step_q <= step_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q  <= PAD'(value);
			bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			sh_q  <= sh_q << BITS_PER_STEP;
			bcd_q <= bcd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (start)
					state_d = F_CONV;
			end
			F_CONV: begin
				if (step_q == SW'(STEPS - 1))
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_status.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign busy      = (state_q != F_IDLE);
	assign push_data = {count, bcd_q};

endmodule

// File: design/b2da_queue.sv
// two-entry queue of converted items between front and back
module b2da_queue import b2da_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output q_status_t    status
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: design/b2da_back.sv
// back end: emits the digits of each queued item, most significant first
module b2da_back import b2da_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_status_t              q_status,
	input  logic [digits_for(VALUE_BITS)*4+$clog2(digits_for(VALUE_BITS)+1)-1:0] head,
	output logic                   pop,
	output logic                   strobe,
	output logic [CHAR_BITS-1:0]   digit_char,
	output logic [TOTAL_BITS-1:0]  digit_total,
	output logic                   is_last
);

	localparam int DIGITS = digits_for(VALUE_BITS);
	localparam int CW     = $clog2(DIGITS + 1);
	localparam int BCD_W  = DIGITS * 4;
	localparam int IW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [BCD_W-1:0]      bcd_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         idx_q;
	logic                  active_q;
	logic                  strobe_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic                  last_q;
	logic                  at_last;
	logic [3:0]            cur_digit;
	logic [CW-1:0]         head_count;

	assign at_last    = (idx_q == '0);
	assign cur_digit  = bcd_q[idx_q*4 +: 4];
	assign head_count = head[BCD_W +: CW];
	// next item loads while the last digit of the current one goes out
	assign pop        = !q_status.empty && (!active_q || at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop)
				active_q <= 1'b1;
			else if (active_q && at_last)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q   <= head[BCD_W-1:0];
			count_q <= head_count;
			idx_q   <= IW'(head_count - CW'(1));
		end else if (active_q && !at_last) begin
			idx_q <= idx_q - IW'(1);
		end
		if (active_q) begin
			char_q  <= ASCII_ZERO + CHAR_BITS'(cur_digit);
			total_q <= TOTAL_BITS'(count_q);
			last_q  <= at_last;
		end
	end

	assign strobe      = strobe_q;
	assign digit_char  = char_q;
	assign digit_total = total_q;
	assign is_last     = last_q;

`ifndef SYNTHESIS
	a_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> strobe)
		else $error("digits of one item not back to back");
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE))
		else $error("digit character out of range");
	a_total_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> digit_total == $past(digit_total))
		else $error("digit total changed within an item");
	a_no_pop_midway: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !at_last |-> !pop)
		else $error("queue popped before last digit");
`endif

endmodule

// File: verif/tb.sv
// testbench for the binary to decimal ascii converter: directed table, random values, digit checks
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b2da_pkg::*;

	localparam int VALUE_BITS     = 32;
	localparam int CLK_HIGH       = 6;
	localparam int CLK_LOW        = 6;
	localparam int RANDOM_ITEMS   = 128;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 20;
	localparam int N_DIRECTED     = 23;

	typedef struct packed {
		logic [CHAR_BITS-1:0]  ch;
		logic [TOTAL_BITS-1:0] total;
		logic                  last;
	} digit_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [VALUE_BITS-1:0] value;
	logic                  strobe;
	logic [CHAR_BITS-1:0]  digit_char;
	logic [TOTAL_BITS-1:0] digit_total;
	logic                  is_last;

	digit_t pending_digits[$];
	string  item_text;
	int     error_count = 0;
	int     items_taken = 0;
	int     digits_seen = 0;
	int     idle_cycles = 0;
	int     burst_left  = 0;
	bit     len_seen[11];

	// text is typed in only where the decimal form is obvious, else the predictor fills it in
	logic [VALUE_BITS-1:0] dir_value[N_DIRECTED] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345, 32'd999999999,
		32'd1000000000, 32'd4294967295, 32'd2147483648, 32'd2147483647, 32'hAAAAAAAA,
		32'h55555555, 32'd1234567890, 32'd9876543, 32'd4000000000, 32'd0, 32'd7,
		32'd65535, 32'd1000, 32'd100000, 32'd42
	};
	string dir_text[N_DIRECTED] = '{
		"0", "1", "9", "10", "99", "100", "", "999999999",
		"1000000000", "4294967295", "2147483648", "", "",
		"", "1234567890", "", "4000000000", "0", "7",
		"", "1000", "", "42"
	};

	binary_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.digit_char (digit_char),
		.digit_total(digit_total),
		.is_last    (is_last)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	function automatic longint unsigned pow10(input int n);
		longint unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// digits of the value, most significant first, no leading zeros
	task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
		logic [3:0]      rev[20];
		longint unsigned rem;
		int              n;
		digit_t          d;
		rem = v;
		n = 0;
		do begin
			rev[n] = 4'(rem % 10);
			rem = rem / 10;
			n++;
		end while (rem != 0);
		for (int k = 0; k < n; k++) begin
			d.ch    = ASCII_ZERO + CHAR_BITS'(rev[n-1-k]);
			d.total = TOTAL_BITS'(n);
			d.last  = (k == n - 1);
			pending_digits.push_back(d);
		end
		if (n <= 10)
			len_seen[n] = 1'b1;
	endtask

	task automatic queue_text_digits(input string s);
		digit_t d;
		for (int k = 0; k < s.len(); k++) begin
			d.ch    = CHAR_BITS'(s[k]);
			d.total = TOTAL_BITS'(s.len());
			d.last  = (k == s.len() - 1);
			pending_digits.push_back(d);
		end
		if (s.len() <= 10)
			len_seen[s.len()] = 1'b1;
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// results are checked before a new item is queued so a stray strobe is never matched to it
	always @(posedge clk) begin : monitor
		digit_t want;
		bit     active;
		if (arst_n) begin
			active = 1'b0;
			if (strobe) begin
				active = 1'b1;
				digits_seen++;
				if (pending_digits.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t ns: digit with nothing expected, got char %0d total %0d last %0b",
							$time, digit_char, digit_total, is_last);
				end else begin
					want = pending_digits.pop_front();
					if (digit_char !== want.ch)
						report_mismatch("digit_char", want.ch, digit_char);
					if (digit_total !== want.total)
						report_mismatch("digit_total", want.total, digit_total);
					if (is_last !== want.last)
						report_mismatch("is_last", want.last, is_last);
				end
			end
			if (start && !busy) begin
				active = 1'b1;
				items_taken++;
				if (item_text.len() != 0)
					queue_text_digits(item_text);
				else
					predict_digits(value);
			end
			idle_cycles = active ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog, no activity for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("binary_to_decimal_ascii regression: fail");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones, and occasional back-to-back bursts
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(5, 15);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [VALUE_BITS-1:0] random_value();
		longint unsigned lo, hi;
		int              n;
		case ($urandom_range(0, 9))
			6: begin
				n = $urandom_range(1, 9);
				return VALUE_BITS'(pow10(n) - longint'($urandom_range(0, 1)));
			end
			7: return $urandom;
			8: return $urandom_range(0, 20);
			9: return 32'hFFFFFFFF - $urandom_range(0, 1000);
			default: begin
				// pick the digit count first so long and short values are equally likely
				n  = $urandom_range(1, 10);
				lo = (n == 1) ? 0 : pow10(n - 1);
				hi = (n == 10) ? 64'hFFFFFFFF : pow10(n) - 1;
				return VALUE_BITS'(lo + ({32'd0, $urandom} % (hi - lo + 1)));
			end
		endcase
	endfunction

	task automatic send_item(input logic [VALUE_BITS-1:0] v, input string text, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			value <= $urandom;
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		item_text = text;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		item_text = "";
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int lengths_hit;
		arst_n    = 1'b0;
		start     = 1'b0;
		value     = '0;
		item_text = "";
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first rows go back to back, the rest with random gaps
		for (int i = 0; i < N_DIRECTED; i++)
			send_item(dir_value[i], dir_text[i], (i < 12) ? 0 : next_gap());
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			send_item(random_value(), "", next_gap());
		end
		wait_drained();

		lengths_hit = 0;
		for (int n = 1; n <= 10; n++)
			lengths_hit += len_seen[n];
		if (pending_digits.size() != 0)
			error_count++;
		$display("covered %0d items (%0d directed, %0d random), %0d digits checked",
			items_taken, N_DIRECTED, RANDOM_ITEMS, digits_seen);
		$display("values of %0d of the 10 possible digit lengths were converted, %0d errors",
			lengths_hit, error_count);
		if (error_count == 0)
			$display("binary_to_decimal_ascii regression: pass");
		else
			$display("binary_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule
